### src/lpf4_pkg.sv
// ============================================================================
// lpf4_pkg
// Shared constants, sequencer control types and step schedule for the
// four-pole ladder low-pass filter.
// ============================================================================
package lpf4_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF  = 32;
    localparam int FRAC_BITS       = 24;

    localparam int CUTOFF_W = 18;
    localparam int GAIN_W   = 19;
    localparam int CFG_W    = 19;
    localparam int COEF_W   = 26;   // signed multiplier B operand

    localparam int K_GAIN  = 22946; // 0.35013 in Q16
    localparam int K_PREV  = 19661; // 0.3 in Q16
    localparam int Q16_ONE = 65536;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 18'd32768;

    // register indexes on the config port
    localparam logic REG_CUTOFF   = 1'b0;
    localparam logic REG_FEEDBACK = 1'b1;

    localparam int               STEP_W    = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd13;

    typedef enum logic [3:0] {
        A_CUTOFF, A_F2, A_KGAIN, A_U, A_Y1, A_Y2, A_Y3, A_Y4,
        A_SPREV, A_P1, A_P2, A_P3
    } a_sel_t;

    typedef enum logic [2:0] {
        B_CUTOFF, B_F2, B_F4, B_GAIN, B_KPREV, B_OMF, B_G
    } b_sel_t;

    // what to do with the product issued in the previous step
    typedef enum logic [3:0] {
        OP_NONE, OP_F2, OP_U, OP_F4, OP_ACC_LOAD, OP_G, OP_ACC_ADD,
        OP_Y1, OP_ACC_Y1, OP_Y2, OP_ACC_Y2, OP_Y3, OP_ACC_Y3, OP_Y4
    } op_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        op_t    op;
        logic   en;
    } ctrl_t;

    function automatic ctrl_t sched(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c.en = 1'b0;
        unique case (step)
            4'd0:  begin c.a_sel = A_CUTOFF; c.b_sel = B_CUTOFF; c.op = OP_NONE;     end
            4'd1:  begin c.a_sel = A_Y4;     c.b_sel = B_GAIN;   c.op = OP_F2;       end
            4'd2:  begin c.a_sel = A_F2;     c.b_sel = B_F2;     c.op = OP_U;        end
            4'd3:  begin c.a_sel = A_SPREV;  c.b_sel = B_KPREV;  c.op = OP_F4;       end
            4'd4:  begin c.a_sel = A_KGAIN;  c.b_sel = B_F4;     c.op = OP_ACC_LOAD; end
            4'd5:  begin c.a_sel = A_Y1;     c.b_sel = B_OMF;    c.op = OP_G;        end
            4'd6:  begin c.a_sel = A_U;      c.b_sel = B_G;      c.op = OP_ACC_ADD;  end
            4'd7:  begin c.a_sel = A_P1;     c.b_sel = B_KPREV;  c.op = OP_Y1;       end
            4'd8:  begin c.a_sel = A_Y2;     c.b_sel = B_OMF;    c.op = OP_ACC_Y1;   end
            4'd9:  begin c.a_sel = A_P2;     c.b_sel = B_KPREV;  c.op = OP_Y2;       end
            4'd10: begin c.a_sel = A_Y3;     c.b_sel = B_OMF;    c.op = OP_ACC_Y2;   end
            4'd11: begin c.a_sel = A_P3;     c.b_sel = B_KPREV;  c.op = OP_Y3;       end
            4'd12: begin c.a_sel = A_Y4;     c.b_sel = B_OMF;    c.op = OP_ACC_Y3;   end
            4'd13: begin c.a_sel = A_CUTOFF; c.b_sel = B_CUTOFF; c.op = OP_Y4;       end
            default: begin c.a_sel = A_CUTOFF; c.b_sel = B_CUTOFF; c.op = OP_NONE;   end
        endcase
        return c;
    endfunction

endpackage

### src/lpf4_mul.sv
// ============================================================================
// lpf4_mul
// Shared signed multiplier with Q16 floor scaling and a registered product.
// ============================================================================
module lpf4_mul import lpf4_pkg::*; #(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [STATE_BITS-1:0]  a,
    input  logic signed [COEF_W-1:0]      b,
    output logic signed [STATE_BITS+COEF_W-17:0] q
);
    localparam int PW = STATE_BITS + COEF_W;

    logic signed [PW-1:0]    prod;
    logic signed [PW-17:0]   q_reg;

    assign prod = PW'(a) * PW'(b);

    // dropping the low 16 bits of a two's complement product is floor(a*b/2^16)
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= prod[PW-1:16];
        end
    end

    assign q = q_reg;
endmodule

### src/lpf4_dp.sv
// ============================================================================
// lpf4_dp
// Filter datapath: operand select, shared multiplier, accumulator,
// saturation and the section state registers.
// ============================================================================
module lpf4_dp import lpf4_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctrl_t                         ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [CUTOFF_W-1:0]           cutoff,
    input  logic [GAIN_W-1:0]             gain,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);
    localparam int S   = STATE_BITS;
    localparam int QW  = S + COEF_W - 16;
    localparam int AW  = S + 12;
    localparam int UP  = FRAC_BITS - (SAMPLE_BITS - 1);
    localparam int F2_W = 21;
    localparam int F4_W = 25;
    localparam int G_W  = 23;

    localparam logic signed [AW-1:0] ST_MAX = {{(AW-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [AW-1:0] ONE    = AW'(1) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] SMP_MAX =
        {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] SMP_MIN = ~SMP_MAX;

    function automatic logic signed [S-1:0] sat_st(input logic signed [AW-1:0] v);
        logic signed [S-1:0] r;
        if (v > ST_MAX) begin
            r = ST_MAX[S-1:0];
        end else if (v < ST_MIN) begin
            r = ST_MIN[S-1:0];
        end else begin
            r = v[S-1:0];
        end
        return r;
    endfunction

    logic signed [S-1:0] y1_reg, y2_reg, y3_reg, y4_reg;
    logic signed [S-1:0] sprev_reg, p1_reg, p2_reg, p3_reg;
    logic signed [S-1:0] u_reg;
    logic signed [AW-1:0] acc_reg;
    logic [F2_W-1:0] f2_reg;
    logic [F4_W-1:0] f4_reg;
    logic [G_W-1:0]  g_reg;

    logic signed [S-1:0]      mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [QW-1:0]     q;
    logic signed [COEF_W-1:0] omf;

    logic signed [AW-1:0] q_ext, x_ext, y4_clamp, out_wide;
    logic signed [S-1:0]  s_sat, y1_next, sum_next, u_next, y4_sat;

    // 1 - f, negative for a cutoff above 1.0
    assign omf = COEF_W'(Q16_ONE) - $signed(COEF_W'(cutoff));

    always_comb begin
        case (ctrl.a_sel)
            A_CUTOFF: mul_a = S'($signed({1'b0, cutoff}));
            A_F2:     mul_a = S'($signed({1'b0, f2_reg}));
            A_KGAIN:  mul_a = S'(K_GAIN);
            A_U:      mul_a = u_reg;
            A_Y1:     mul_a = y1_reg;
            A_Y2:     mul_a = y2_reg;
            A_Y3:     mul_a = y3_reg;
            A_Y4:     mul_a = y4_reg;
            A_SPREV:  mul_a = sprev_reg;
            A_P1:     mul_a = p1_reg;
            A_P2:     mul_a = p2_reg;
            A_P3:     mul_a = p3_reg;
            default:  mul_a = '0;
        endcase
        case (ctrl.b_sel)
            B_CUTOFF: mul_b = COEF_W'($signed({1'b0, cutoff}));
            B_F2:     mul_b = COEF_W'($signed({1'b0, f2_reg}));
            B_F4:     mul_b = $signed({1'b0, f4_reg});
            B_GAIN:   mul_b = COEF_W'($signed({1'b0, gain}));
            B_KPREV:  mul_b = COEF_W'(K_PREV);
            B_OMF:    mul_b = omf;
            B_G:      mul_b = COEF_W'($signed({1'b0, g_reg}));
            default:  mul_b = '0;
        endcase
    end

    lpf4_mul #(
        .STATE_BITS(STATE_BITS)
    ) u_mul (
        .aclk (aclk),
        .en   (ctrl.en),
        .a    (mul_a),
        .b    (mul_b),
        .q    (q)
    );

    always_comb begin
        q_ext    = AW'(q);
        x_ext    = AW'(sample) <<< UP;
        u_next   = sat_st(x_ext - q_ext);
        s_sat    = sat_st(q_ext);
        y1_next  = sat_st(acc_reg + AW'(s_sat));
        sum_next = sat_st(acc_reg + q_ext);
        y4_sat   = sum_next;
        if (AW'(y4_sat) > ONE) begin
            y4_clamp = ONE;
        end else if (AW'(y4_sat) < -ONE) begin
            y4_clamp = -ONE;
        end else begin
            y4_clamp = AW'(y4_sat);
        end
        out_wide = y4_clamp >>> UP;
        if (out_wide > SMP_MAX) begin
            out_sample = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (out_wide < SMP_MIN) begin
            out_sample = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            out_sample = out_wide[SAMPLE_BITS-1:0];
        end
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y1_reg    <= '0;
            y2_reg    <= '0;
            y3_reg    <= '0;
            y4_reg    <= '0;
            sprev_reg <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            p3_reg    <= '0;
        end else if (ctrl.en) begin
            case (ctrl.op)
                OP_Y1: begin
                    sprev_reg <= s_sat;
                    y1_reg    <= y1_next;
                end
                OP_ACC_Y1: p1_reg <= y1_reg;
                OP_Y2:     y2_reg <= sum_next;
                OP_ACC_Y2: p2_reg <= y2_reg;
                OP_Y3:     y3_reg <= sum_next;
                OP_ACC_Y3: p3_reg <= y3_reg;
                OP_Y4:     y4_reg <= y4_clamp[S-1:0];
                default: ;
            endcase
        end
    end

    // per-item scratch
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            case (ctrl.op)
                OP_F2:       f2_reg  <= q[F2_W-1:0];
                OP_U:        u_reg   <= u_next;
                OP_F4:       f4_reg  <= q[F4_W-1:0];
                OP_ACC_LOAD: acc_reg <= q_ext;
                OP_G:        g_reg   <= q[G_W-1:0];
                OP_ACC_ADD:  acc_reg <= acc_reg + q_ext;
                OP_ACC_Y1:   acc_reg <= AW'(y1_reg) + q_ext;
                OP_ACC_Y2:   acc_reg <= AW'(y2_reg) + q_ext;
                OP_ACC_Y3:   acc_reg <= AW'(y3_reg) + q_ext;
                default: ;
            endcase
        end
    end
endmodule

### src/four_pole_ladder_lowpass.sv
// ============================================================================
// four_pole_ladder_lowpass
// Four-pole resonant ladder low-pass filter, one Q1.15 sample in, one out,
// computed on a single shared multiplier under a step sequencer.
// ============================================================================
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_sample_in   [SAMPLE_BITS] signed
//  m_        out  m_valid / m_ready   m_sample_out  [SAMPLE_BITS] signed
//  cfg_      in   cfg_wr_en           cfg_addr, cfg_wdata [19]
//
//  An item takes 14 sequencer steps, one multiply per step on the shared
//  multiplier; the next item is accepted only once the sequencer is idle.
//  The result is valid the cycle after the last step; s_ready is high only idle.
//  A waiting result does not block the next item; the last step holds until
//  the output register is free.
//  Synchronous reset zeroes the filter state and sets the cutoff to 0.5.
// ============================================================================
module four_pole_ladder_lowpass import lpf4_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [CFG_W-1:0]              cfg_wdata
);
    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                        state_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CUTOFF_W-1:0]           cutoff_reg;
    logic [GAIN_W-1:0]             gain_reg;

    ctrl_t                         ctrl;
    logic                          last_step;
    logic                          item_done;
    logic signed [SAMPLE_BITS-1:0] dp_out;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign last_step    = (step_reg == LAST_STEP);
    assign item_done    = (state_reg == ST_RUN) && ctrl.en && last_step;

    always_comb begin
        ctrl    = sched(step_reg);
        ctrl.en = (state_reg == ST_RUN) && (!last_step || !m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
            gain_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CUTOFF:   cutoff_reg <= cfg_wdata[CUTOFF_W-1:0];
                REG_FEEDBACK: gain_reg   <= cfg_wdata[GAIN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result may land in the same cycle the old one transfers
            if (item_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample_in;
                        step_reg   <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (ctrl.en) begin
                        if (last_step) begin
                            m_sample_reg <= dp_out;
                            state_reg    <= ST_IDLE;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    lpf4_dp #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .STATE_BITS (STATE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .sample     (sample_reg),
        .cutoff     (cutoff_reg),
        .gain       (gain_reg),
        .out_sample (dp_out)
    );

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("transfer in did not start the sequencer at step zero");

    a_result_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_RUN && last_step))
        else $error("result raised outside the last step");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= LAST_STEP))
        else $error("step counter past the schedule");

    a_hold_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && last_step && m_valid && !m_ready)
        |=> (state_reg == ST_RUN && last_step))
        else $error("last step finished while the output register was full");
endmodule
